FILE: design/tcspl_pkg.sv
// tcspl_pkg: widths, sizes, operation and status codes, and the command
// bundle shared by the two-class sorted priority list.
// No dependencies.
package tcspl_pkg;

    // List size and derived widths
    localparam int CAPACITY   = 64;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SCAN_STEPS = $clog2(CAPACITY);

    // Field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 27;
    localparam int AMT_W    = 48;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 7;

    // Common width for position and count compares
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Read gather: cells are ORed in groups, then groups are ORed
    localparam int RD_GRP  = 8;
    localparam int RD_NGRP = (CAPACITY + RD_GRP - 1) / RD_GRP;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input beat
        logic compare;  // cells compare against the key, flags registered
        logic commit;   // list, count and result register update
    } t_cmd;

endpackage

FILE: design/tcspl_scan.sv
// tcspl_scan: inclusive prefix OR across the cell row, index 0 upwards,
// built as a log-depth scan. Depends on tcspl_pkg.
module tcspl_scan import tcspl_pkg::*; (
    input  logic [CAPACITY-1:0] i_vec,
    output logic [CAPACITY-1:0] o_pre
);

    logic [CAPACITY-1:0] w_lvl [SCAN_STEPS+1];

    assign w_lvl[0] = i_vec;

    // each level folds in the bits 2**s places below
    for (genvar s = 0; s < SCAN_STEPS; s++) begin : g_lvl
        assign w_lvl[s+1] = w_lvl[s] | (w_lvl[s] << (1 << s));
    end

    assign o_pre = w_lvl[SCAN_STEPS];

endmodule

FILE: design/tcspl_ctrl.sv
// tcspl_ctrl: sequencer for the sorted list. Handles both handshakes and
// the result valid flag, and issues load / compare / commit commands.
// Depends on tcspl_pkg.
module tcspl_ctrl import tcspl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPARE = 3'b010,
        S_COMMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_can_commit;
    logic   w_commit;
    logic   w_ready;
    logic   w_load;

    // commit only when the result register is free or being drained
    assign w_can_commit = !r_out_valid || !i_out_stall;
    assign w_commit     = (r_state == S_COMMIT) && w_can_commit;
    assign w_ready      = (r_state == S_IDLE) || w_commit;
    assign w_load       = i_in_valid && w_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load) n_state = S_COMPARE;
            end
            S_COMPARE: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_commit) n_state = w_load ? S_COMPARE : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid: set on commit, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = !w_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.load    = w_load;
    assign o_cmd.compare = (r_state == S_COMPARE);
    assign o_cmd.commit  = w_commit;

endmodule

FILE: design/tcspl_dp.sv
// tcspl_dp: datapath of the sorted list. Row of entry cells with parallel
// key compare, shift-in / shift-out, in-place update, read gather, entry
// count and result register. Depends on tcspl_pkg and tcspl_scan.
module tcspl_dp import tcspl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [OP_W-1:0]         i_op,
    input  logic [ID_W-1:0]         i_client_id,
    input  logic signed [AMT_W-1:0] i_amount,
    input  logic                    i_premium,
    input  logic [POS_W-1:0]        i_position,
    output logic [STATUS_W-1:0]     o_status,
    output logic [ECNT_W-1:0]       o_entry_count,
    output logic [ID_W-1:0]         o_read_id,
    output logic signed [AMT_W-1:0] o_read_amount,
    output logic                    o_read_premium
);

    // captured beat
    t_op                     r_op;
    logic [ID_W-1:0]         r_id;
    logic signed [AMT_W-1:0] r_amt;
    logic                    r_prem;
    logic [POS_W-1:0]        r_pos;

    // cell row and count
    logic [ID_W-1:0]         r_cid  [CAPACITY];
    logic signed [AMT_W-1:0] r_camt [CAPACITY];
    logic                    r_cprem [CAPACITY];
    logic [ID_W-1:0]         n_cid  [CAPACITY];
    logic signed [AMT_W-1:0] n_camt [CAPACITY];
    logic                    n_cprem [CAPACITY];
    logic [CNT_W-1:0]        r_count, n_count;

    // compare-stage flags
    logic [CAPACITY-1:0] w_vld, w_pred, w_match, w_rsel;
    logic [CAPACITY-1:0] r_vld, r_pred, r_match;
    logic                w_pos_bad, r_pos_bad;

    // read gather
    logic [ID_W-1:0]         w_gp_id   [RD_NGRP][RD_GRP];
    logic [AMT_W-1:0]        w_gp_amt  [RD_NGRP][RD_GRP];
    logic                    w_gp_prem [RD_NGRP][RD_GRP];
    logic [ID_W-1:0]         w_gid   [RD_NGRP];
    logic [AMT_W-1:0]        w_gamt  [RD_NGRP];
    logic                    w_gprem [RD_NGRP];
    logic [ID_W-1:0]         r_gid   [RD_NGRP];
    logic [AMT_W-1:0]        r_gamt  [RD_NGRP];
    logic                    r_gprem [RD_NGRP];
    logic [ID_W-1:0]         w_rd_id;
    logic [AMT_W-1:0]        w_rd_amt;
    logic                    w_rd_prem;

    // commit-stage decode
    logic [CAPACITY-1:0] w_pre_p, w_pre_m, w_pred_rev, w_suf_rev, w_suf_p;
    logic [CAPACITY-1:0] w_shift, w_head, w_first;
    logic                w_full, w_found;
    logic                w_ins_go, w_del_go, w_upd_go, w_rd_go;
    t_status             w_status;

    // result register
    t_status                 r_res_status;
    logic [ECNT_W-1:0]       r_res_cnt;
    logic [ID_W-1:0]         r_res_id;
    logic signed [AMT_W-1:0] r_res_amt;
    logic                    r_res_prem;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_id   <= i_client_id;
            r_amt  <= i_amount;
            r_prem <= i_premium;
            r_pos  <= i_position;
        end
    end

    // per-cell compare against the key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
        assign w_vld[g]   = CNT_W'(g) < r_count;
        assign w_pred[g]  = w_vld[g] && (r_prem ?
                            (!r_cprem[g] || (r_camt[g] >= r_amt)) :
                            ( r_cprem[g] || (r_camt[g] <= r_amt)));
        assign w_match[g] = w_vld[g] && (r_cid[g] == r_id);
        assign w_rsel[g]  = w_vld[g] && (WIDE_W'(g) == WIDE_W'(r_pos));
    end

    assign w_pos_bad = WIDE_W'(r_pos) >= WIDE_W'(r_count);

    // first level of the read gather: select within groups of cells
    for (genvar gg = 0; gg < RD_NGRP; gg++) begin : g_grp
        for (genvar kk = 0; kk < RD_GRP; kk++) begin : g_mem
            localparam int CI = gg * RD_GRP + kk;
            if (CI < CAPACITY) begin : g_cell
                assign w_gp_id[gg][kk]   = w_rsel[CI] ? r_cid[CI] : '0;
                assign w_gp_amt[gg][kk]  = w_rsel[CI] ? r_camt[CI] : '0;
                assign w_gp_prem[gg][kk] = w_rsel[CI] && r_cprem[CI];
            end else begin : g_pad
                assign w_gp_id[gg][kk]   = '0;
                assign w_gp_amt[gg][kk]  = '0;
                assign w_gp_prem[gg][kk] = 1'b0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < RD_NGRP; g++) begin
            w_gid[g]   = '0;
            w_gamt[g]  = '0;
            w_gprem[g] = 1'b0;
            for (int k = 0; k < RD_GRP; k++) begin
                w_gid[g]   = w_gid[g]   | w_gp_id[g][k];
                w_gamt[g]  = w_gamt[g]  | w_gp_amt[g][k];
                w_gprem[g] = w_gprem[g] | w_gp_prem[g][k];
            end
        end
    end

    // compare stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_vld     <= w_vld;
            r_pred    <= w_pred;
            r_match   <= w_match;
            r_pos_bad <= w_pos_bad;
            for (int g = 0; g < RD_NGRP; g++) begin
                r_gid[g]   <= w_gid[g];
                r_gamt[g]  <= w_gamt[g];
                r_gprem[g] <= w_gprem[g];
            end
        end
    end

    // second level of the read gather
    always_comb begin
        w_rd_id   = '0;
        w_rd_amt  = '0;
        w_rd_prem = 1'b0;
        for (int g = 0; g < RD_NGRP; g++) begin
            w_rd_id   = w_rd_id   | r_gid[g];
            w_rd_amt  = w_rd_amt  | r_gamt[g];
            w_rd_prem = w_rd_prem | r_gprem[g];
        end
    end

    // prefix scans: first insert hit, first id match, last premium hit
    tcspl_scan u_scan_pred (
        .i_vec (r_pred),
        .o_pre (w_pre_p)
    );

    tcspl_scan u_scan_match (
        .i_vec (r_match),
        .o_pre (w_pre_m)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_rev
        assign w_pred_rev[g] = r_pred[CAPACITY-1-g];
        assign w_suf_p[g]    = w_suf_rev[CAPACITY-1-g];
    end

    tcspl_scan u_scan_suffix (
        .i_vec (w_pred_rev),
        .o_pre (w_suf_rev)
    );

    // cells at or past the insert point move one place towards the tail;
    // regular keys land before the first hit, premium after the last
    assign w_shift = r_prem ? ~w_suf_p : (w_pre_p | ~r_vld);

    assign w_full  = r_count >= CNT_W'(CAPACITY);
    assign w_found = w_pre_m[CAPACITY-1];

    assign w_ins_go = i_cmd.commit && (r_op == OP_INSERT) && !w_full;
    assign w_del_go = i_cmd.commit && (r_op == OP_DELETE) && w_found;
    assign w_upd_go = i_cmd.commit && (r_op == OP_UPDATE) && w_found;
    assign w_rd_go  = (r_op == OP_READ) && !r_pos_bad;

    // cell next values
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_head[g]  = w_shift[g];
            assign w_first[g] = r_match[g];
        end else begin : g_rest
            assign w_head[g]  = w_shift[g] && !w_shift[g-1];
            assign w_first[g] = r_match[g] && !w_pre_m[g-1];
        end

        if (g == 0 && g == CAPACITY - 1) begin : g_only
            assign n_cid[g]   = (w_ins_go && w_shift[g]) ? r_id : r_cid[g];
            assign n_cprem[g] = (w_ins_go && w_shift[g]) ? r_prem : r_cprem[g];
            assign n_camt[g]  = (w_ins_go && w_shift[g]) ? r_amt :
                                (w_upd_go && w_first[g]) ? r_amt : r_camt[g];
        end else if (g == 0) begin : g_head
            assign n_cid[g]   = (w_ins_go && w_shift[g]) ? r_id :
                                (w_del_go && w_pre_m[g]) ? r_cid[g+1] : r_cid[g];
            assign n_cprem[g] = (w_ins_go && w_shift[g]) ? r_prem :
                                (w_del_go && w_pre_m[g]) ? r_cprem[g+1] : r_cprem[g];
            assign n_camt[g]  = (w_ins_go && w_shift[g]) ? r_amt :
                                (w_del_go && w_pre_m[g]) ? r_camt[g+1] :
                                (w_upd_go && w_first[g]) ? r_amt : r_camt[g];
        end else if (g == CAPACITY - 1) begin : g_tail
            assign n_cid[g]   = (w_ins_go && w_shift[g]) ?
                                (w_head[g] ? r_id : r_cid[g-1]) : r_cid[g];
            assign n_cprem[g] = (w_ins_go && w_shift[g]) ?
                                (w_head[g] ? r_prem : r_cprem[g-1]) : r_cprem[g];
            assign n_camt[g]  = (w_ins_go && w_shift[g]) ?
                                (w_head[g] ? r_amt : r_camt[g-1]) :
                                (w_upd_go && w_first[g]) ? r_amt : r_camt[g];
        end else begin : g_mid
            assign n_cid[g]   = (w_ins_go && w_shift[g]) ?
                                (w_head[g] ? r_id : r_cid[g-1]) :
                                (w_del_go && w_pre_m[g]) ? r_cid[g+1] : r_cid[g];
            assign n_cprem[g] = (w_ins_go && w_shift[g]) ?
                                (w_head[g] ? r_prem : r_cprem[g-1]) :
                                (w_del_go && w_pre_m[g]) ? r_cprem[g+1] : r_cprem[g];
            assign n_camt[g]  = (w_ins_go && w_shift[g]) ?
                                (w_head[g] ? r_amt : r_camt[g-1]) :
                                (w_del_go && w_pre_m[g]) ? r_camt[g+1] :
                                (w_upd_go && w_first[g]) ? r_amt : r_camt[g];
        end
    end

    // cell storage, no reset: cells past the count are never read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int g = 0; g < CAPACITY; g++) begin
                r_cid[g]   <= n_cid[g];
                r_camt[g]  <= n_camt[g];
                r_cprem[g] <= n_cprem[g];
            end
        end
    end

    // count
    always_comb begin
        n_count = r_count;
        if (w_ins_go) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del_go) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // status of the beat
    always_comb begin
        unique case (r_op) inside
            OP_INSERT:            w_status = w_full ? ST_FULL : ST_OK;
            OP_DELETE, OP_UPDATE: w_status = w_found ? ST_OK : ST_NOT_FOUND;
            OP_READ:              w_status = r_pos_bad ? ST_RANGE : ST_OK;
            default:              w_status = ST_OK;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_status <= w_status;
            r_res_cnt    <= ECNT_W'(n_count);
            r_res_id     <= w_rd_go ? w_rd_id : '0;
            r_res_amt    <= w_rd_go ? w_rd_amt : '0;
            r_res_prem   <= w_rd_go && w_rd_prem;
        end
    end

    assign o_status       = r_res_status;
    assign o_entry_count  = r_res_cnt;
    assign o_read_id      = r_res_id;
    assign o_read_amount  = r_res_amt;
    assign o_read_premium = r_res_prem;

endmodule

FILE: design/two_class_sorted_priority_list.sv
// two_class_sorted_priority_list: top level of the bounded two-class sorted
// list. Joins the sequencer and the cell datapath. Depends on tcspl_pkg,
// tcspl_ctrl, tcspl_dp.
//
//  channel  direction  handshake                   fields
//  -------  ---------  --------------------------  ------------------------------
//  in       input      i_in_valid / o_in_stall     op, client_id, amount,
//                                                  premium, position
//  out      output     o_out_valid / i_out_stall   status, entry_count, read_id,
//                                                  read_amount, read_premium
//
// Each beat passes through a compare state, in which every cell compares its
// entry with the key in parallel, and a commit state, in which the row shifts
// or updates, the count moves and the result register loads. The next beat is
// taken in the commit state, so a new beat is accepted while the last commits.
// A held result stalls the commit cycle until it is taken; the input side
// stalls meanwhile. Reset empties the list (count to zero); cell contents are
// not cleared.
module two_class_sorted_priority_list import tcspl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_op,
    input  logic [ID_W-1:0]         i_client_id,
    input  logic signed [AMT_W-1:0] i_amount,
    input  logic                    i_premium,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [STATUS_W-1:0]     o_status,
    output logic [ECNT_W-1:0]       o_entry_count,
    output logic [ID_W-1:0]         o_read_id,
    output logic signed [AMT_W-1:0] o_read_amount,
    output logic                    o_read_premium
);

    t_cmd w_cmd;

    tcspl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    tcspl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_client_id    (i_client_id),
        .i_amount       (i_amount),
        .i_premium      (i_premium),
        .i_position     (i_position),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_read_id      (o_read_id),
        .o_read_amount  (o_read_amount),
        .o_read_premium (o_read_premium)
    );

endmodule
